/* rtl/core/bmm_pkg.sv */
package bmm_pkg;

  localparam int ADDR_W  = 16;
  localparam int OFF_W   = 19;
  localparam int DATA_W  = 8;
  localparam int BANK_W  = 5;
  localparam int SIZE_W  = 20;
  localparam int PAGE_W  = 14;   // offset within one 16 KiB ROM bank
  localparam int WIN_W   = 13;   // offset within one 8 KiB window

  localparam int BOOT_BYTES = 256;
  localparam int BOOT_AW    = 8;
  localparam int VRAM_BYTES = 8192;
  localparam int WRAM_BYTES = 8192;
  localparam int HIGH_BYTES = 512;  // 0xFE00-0xFFFF: object RAM, IO and high RAM
  localparam int HIGH_AW    = 9;

  localparam logic [OFF_W-1:0]  HEADER_OFF       = 19'h00147;
  localparam logic [SIZE_W-1:0] MBC_MIN_SIZE     = 20'h00148;
  localparam logic [ADDR_W-1:0] OVERLAY_OFF_ADDR = 16'hFF50;
  localparam logic [3:0]        RAM_EN_CODE      = 4'hA;
  localparam logic [DATA_W-1:0] FILL_BYTE        = 8'hFF;
  localparam logic [BANK_W-1:0] BANK_ONE         = 5'd1;
  localparam logic [DATA_W-1:0] CART_TYPE_MIN    = 8'd1;
  localparam logic [DATA_W-1:0] CART_TYPE_MAX    = 8'd3;

  typedef enum logic [1:0] {
    CMD_READ      = 2'd0,
    CMD_WRITE     = 2'd1,
    CMD_LOAD_CART = 2'd2,
    CMD_LOAD_BOOT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RGN_ROM0 = 3'd0,
    RGN_ROMX = 3'd1,
    RGN_VRAM = 3'd2,
    RGN_CRAM = 3'd3,
    RGN_WRAM = 3'd4,
    RGN_HIGH = 3'd5,
    RGN_NONE = 3'd6,
    RGN_IE   = 3'd7
  } region_t;

  typedef struct packed {
    cmd_t               cmd;
    region_t            region;
    logic               low_page;     // below 0x0100, boot overlay window
    logic               ram_en_area;  // below 0x2000, RAM enable register
    logic               overlay_off;  // write to 0xFF50
    logic               load_ok;      // load offset inside its ROM
    logic               header;       // load offset hits the cartridge type byte
    logic [ADDR_W-1:0]  addr;
    logic [OFF_W-1:0]   offset;
    logic [DATA_W-1:0]  data;
  } req_t;

endpackage

/* rtl/core/bmm_queue.sv */
module bmm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

endmodule

/* rtl/core/bmm_front.sv */
module bmm_front #(
  parameter int ROM_BYTES = 524288
) (
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   cmd,
  input  logic [bmm_pkg::ADDR_W-1:0]   bus_address,
  input  logic [bmm_pkg::OFF_W-1:0]    load_offset,
  input  logic [bmm_pkg::DATA_W-1:0]   write_data,
  input  logic                         q_full,
  input  logic                         clearing,
  output logic                         q_push,
  output bmm_pkg::req_t                req
);

  bmm_pkg::cmd_t    op;
  bmm_pkg::region_t region;

  assign op     = bmm_pkg::cmd_t'(cmd);
  assign full   = q_full || clearing;
  assign q_push = push && !full;

  // Split the bus address into its region of the memory map.
  always_comb begin
    if (bus_address < 16'h4000)       region = bmm_pkg::RGN_ROM0;
    else if (bus_address < 16'h8000)  region = bmm_pkg::RGN_ROMX;
    else if (bus_address < 16'hA000)  region = bmm_pkg::RGN_VRAM;
    else if (bus_address < 16'hC000)  region = bmm_pkg::RGN_CRAM;
    else if (bus_address < 16'hFE00)  region = bmm_pkg::RGN_WRAM;
    else if (bus_address <= 16'hFE9F) region = bmm_pkg::RGN_HIGH;
    else if (bus_address < 16'hFF00)  region = bmm_pkg::RGN_NONE;
    else if (bus_address < 16'hFFFF)  region = bmm_pkg::RGN_HIGH;
    else                              region = bmm_pkg::RGN_IE;
  end

  always_comb begin
    req             = '0;
    req.cmd         = op;
    req.region      = region;
    req.low_page    = (bus_address < 16'h0100);
    req.ram_en_area = (bus_address < 16'h2000);
    req.overlay_off = (bus_address == bmm_pkg::OVERLAY_OFF_ADDR);
    req.header      = (load_offset == bmm_pkg::HEADER_OFF);
    req.addr        = bus_address;
    req.offset      = load_offset;
    req.data        = write_data;
    unique case (op)
      bmm_pkg::CMD_LOAD_CART: req.load_ok = (32'(load_offset) < ROM_BYTES);
      bmm_pkg::CMD_LOAD_BOOT: req.load_ok = (32'(load_offset) < bmm_pkg::BOOT_BYTES);
      default:                req.load_ok = 1'b0;
    endcase
  end

endmodule

/* rtl/core/bmm_back.sv */
module bmm_back #(
  parameter int ROM_BYTES      = 524288,
  parameter int CART_RAM_BYTES = 8192
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [bmm_pkg::SIZE_W-1:0]   cfg_data,
  input  bmm_pkg::req_t                req,
  input  logic                         req_empty,
  output logic                         req_pop,
  output logic                         clearing,
  input  logic                         pop,
  output logic                         empty,
  output logic [bmm_pkg::DATA_W-1:0]   read_data
);

  localparam int ROM_AW    = $clog2(ROM_BYTES);
  localparam int CRAM_AW   = $clog2(CART_RAM_BYTES);
  localparam int RES_DEPTH = 4;
  localparam int RCW       = $clog2(RES_DEPTH + 1);

  typedef enum logic [2:0] {
    SRC_FF   = 3'd0,
    SRC_BOOT = 3'd1,
    SRC_ROM  = 3'd2,
    SRC_VRAM = 3'd3,
    SRC_CRAM = 3'd4,
    SRC_WRAM = 3'd5,
    SRC_HIGH = 3'd6,
    SRC_IE   = 3'd7
  } src_t;

  logic [bmm_pkg::DATA_W-1:0] boot_mem [bmm_pkg::BOOT_BYTES];
  logic [bmm_pkg::DATA_W-1:0] rom_mem  [ROM_BYTES];
  logic [bmm_pkg::DATA_W-1:0] vram_mem [bmm_pkg::VRAM_BYTES];
  logic [bmm_pkg::DATA_W-1:0] cram_mem [CART_RAM_BYTES];
  logic [bmm_pkg::DATA_W-1:0] wram_mem [bmm_pkg::WRAM_BYTES];
  logic [bmm_pkg::DATA_W-1:0] high_mem [bmm_pkg::HIGH_BYTES];

  logic [bmm_pkg::DATA_W-1:0] boot_rd, rom_rd, vram_rd, cram_rd, wram_rd, high_rd;

  logic [bmm_pkg::SIZE_W-1:0] cart_rom_bytes;
  logic [bmm_pkg::BANK_W-1:0] rom_bank;
  logic [bmm_pkg::DATA_W-1:0] irq_enable;
  logic                       ram_on;
  logic                       banking_present;
  logic                       overlay_on;
  logic [CRAM_AW-1:0]         clear_cnt;

  logic                       s2_valid;
  src_t                       s2_src;
  logic [bmm_pkg::DATA_W-1:0] s2_ie;

  logic                       issue, is_read, is_write, is_load_cart, is_load_boot;
  logic                       mbc;
  logic [bmm_pkg::OFF_W-1:0]  rom_off;
  logic                       rom_ok;
  logic [bmm_pkg::WIN_W-1:0]  cram_off;
  logic                       cram_ok;
  src_t                       src;
  logic [bmm_pkg::BANK_W-1:0] bank_sel;
  logic                       vram_we, wram_we, high_we, cram_we, rom_we, boot_we;
  logic [CRAM_AW-1:0]         cram_wa;
  logic [bmm_pkg::DATA_W-1:0] cram_wd;
  logic [bmm_pkg::DATA_W-1:0] res_data;
  logic [RCW-1:0]             res_count;

  // Hold off while the result queue could not take every read in flight.
  assign issue        = !req_empty && !clearing &&
                        ((int'(res_count) + int'(s2_valid)) < RES_DEPTH);
  assign req_pop      = issue;
  assign is_read      = issue && (req.cmd == bmm_pkg::CMD_READ);
  assign is_write     = issue && (req.cmd == bmm_pkg::CMD_WRITE);
  assign is_load_cart = issue && (req.cmd == bmm_pkg::CMD_LOAD_CART);
  assign is_load_boot = issue && (req.cmd == bmm_pkg::CMD_LOAD_BOOT);

  assign mbc = banking_present && (cart_rom_bytes >= bmm_pkg::MBC_MIN_SIZE);

  assign rom_off = (req.region == bmm_pkg::RGN_ROMX)
                 ? {rom_bank, req.addr[bmm_pkg::PAGE_W-1:0]}
                 : {{bmm_pkg::BANK_W{1'b0}}, req.addr[bmm_pkg::PAGE_W-1:0]};
  assign rom_ok  = ({1'b0, rom_off} < cart_rom_bytes) && (32'(rom_off) < ROM_BYTES);

  assign cram_off = req.addr[bmm_pkg::WIN_W-1:0];
  assign cram_ok  = (32'(cram_off) < CART_RAM_BYTES);

  // Bank number zero selects bank one.
  assign bank_sel = (req.data[bmm_pkg::BANK_W-1:0] == '0)
                  ? bmm_pkg::BANK_ONE : req.data[bmm_pkg::BANK_W-1:0];

  always_comb begin
    if (overlay_on && req.low_page) begin
      src = SRC_BOOT;
    end else begin
      unique case (req.region)
        bmm_pkg::RGN_ROM0,
        bmm_pkg::RGN_ROMX: src = rom_ok ? SRC_ROM : SRC_FF;
        bmm_pkg::RGN_VRAM: src = SRC_VRAM;
        bmm_pkg::RGN_CRAM: src = (ram_on && cram_ok) ? SRC_CRAM : SRC_FF;
        bmm_pkg::RGN_WRAM: src = SRC_WRAM;
        bmm_pkg::RGN_HIGH: src = SRC_HIGH;
        bmm_pkg::RGN_IE:   src = SRC_IE;
        default:           src = SRC_FF;
      endcase
    end
  end

  assign vram_we = is_write && (req.region == bmm_pkg::RGN_VRAM);
  assign wram_we = is_write && (req.region == bmm_pkg::RGN_WRAM);
  assign high_we = is_write && (req.region == bmm_pkg::RGN_HIGH);
  assign cram_we = clearing ||
                   (is_write && (req.region == bmm_pkg::RGN_CRAM) && ram_on && cram_ok);
  assign rom_we  = is_load_cart && req.load_ok;
  assign boot_we = is_load_boot && req.load_ok;
  assign cram_wa = clearing ? clear_cnt : cram_off[CRAM_AW-1:0];
  assign cram_wd = clearing ? '0 : req.data;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cart_rom_bytes  <= '0;
      rom_bank        <= bmm_pkg::BANK_ONE;
      irq_enable      <= '0;
      ram_on          <= 1'b0;
      banking_present <= 1'b0;
      overlay_on      <= 1'b1;
      clearing        <= 1'b1;
      clear_cnt       <= '0;
      s2_valid        <= 1'b0;
    end else begin
      if (cfg_write) cart_rom_bytes <= cfg_data;
      if (clearing) begin
        clear_cnt <= clear_cnt + 1'b1;
        if (clear_cnt == CRAM_AW'(CART_RAM_BYTES - 1)) clearing <= 1'b0;
      end
      if (is_write && mbc && (req.region == bmm_pkg::RGN_ROM0)) begin
        if (req.ram_en_area) ram_on <= (req.data[3:0] == bmm_pkg::RAM_EN_CODE);
        else                 rom_bank <= bank_sel;
      end
      if (is_write && (req.region == bmm_pkg::RGN_IE)) irq_enable <= req.data;
      if (is_write && req.overlay_off) overlay_on <= 1'b0;
      if (boot_we) overlay_on <= 1'b1;
      if (rom_we && req.header) begin
        banking_present <= (req.data >= bmm_pkg::CART_TYPE_MIN) &&
                           (req.data <= bmm_pkg::CART_TYPE_MAX);
      end
      s2_valid <= is_read;
    end
  end

  always_ff @(posedge clk) begin
    s2_src <= src;
    s2_ie  <= irq_enable;
  end

  // Memories
  always_ff @(posedge clk) begin
    if (boot_we) boot_mem[req.offset[bmm_pkg::BOOT_AW-1:0]] <= req.data;
    boot_rd <= boot_mem[req.addr[bmm_pkg::BOOT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rom_we) rom_mem[req.offset[ROM_AW-1:0]] <= req.data;
    rom_rd <= rom_mem[rom_off[ROM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (vram_we) vram_mem[req.addr[bmm_pkg::WIN_W-1:0]] <= req.data;
    vram_rd <= vram_mem[req.addr[bmm_pkg::WIN_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cram_we) cram_mem[cram_wa] <= cram_wd;
    cram_rd <= cram_mem[cram_off[CRAM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wram_we) wram_mem[req.addr[bmm_pkg::WIN_W-1:0]] <= req.data;
    wram_rd <= wram_mem[req.addr[bmm_pkg::WIN_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (high_we) high_mem[req.addr[bmm_pkg::HIGH_AW-1:0]] <= req.data;
    high_rd <= high_mem[req.addr[bmm_pkg::HIGH_AW-1:0]];
  end

  always_comb begin
    unique case (s2_src)
      SRC_BOOT: res_data = boot_rd;
      SRC_ROM:  res_data = rom_rd;
      SRC_VRAM: res_data = vram_rd;
      SRC_CRAM: res_data = cram_rd;
      SRC_WRAM: res_data = wram_rd;
      SRC_HIGH: res_data = high_rd;
      SRC_IE:   res_data = s2_ie;
      default:  res_data = bmm_pkg::FILL_BYTE;
    endcase
  end

  bmm_queue #(
    .WIDTH (bmm_pkg::DATA_W),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (s2_valid),
    .wdata (res_data),
    .full  (),
    .pop   (pop),
    .rdata (read_data),
    .empty (empty),
    .count (res_count)
  );

endmodule

/* rtl/core/banked_memory_map_mbc1.sv */
// Read data passes the request queue, a registered memory read and the result queue.
// One request per cycle while full is low; each takes one decode and one memory access.
// The result queue holds four bytes; with pop held low the back end stalls once it is full.
// Reset (rst, synchronous): bank 1, overlay on, RAM gate and banking off, IE zero.
// After reset a clearing pass zeroes cartridge RAM, one byte a cycle, over all CART_RAM_BYTES
// bytes (8192 by default); full stays high throughout, configuration writes still land.
module banked_memory_map_mbc1 #(
  parameter int ROM_BYTES      = 524288,
  parameter int CART_RAM_BYTES = 8192
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration: cartridge ROM size in bytes
  input  logic                         cfg_write,
  input  logic [bmm_pkg::SIZE_W-1:0]   cfg_data,
  // request side
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   cmd,
  input  logic [bmm_pkg::ADDR_W-1:0]   bus_address,
  input  logic [bmm_pkg::OFF_W-1:0]    load_offset,
  input  logic [bmm_pkg::DATA_W-1:0]   write_data,
  // result side
  output logic                         empty,
  input  logic                         pop,
  output logic [bmm_pkg::DATA_W-1:0]   read_data
);

  localparam int REQ_DEPTH = 2;

  bmm_pkg::req_t front_req;
  bmm_pkg::req_t back_req;
  logic          req_push;
  logic          req_full;
  logic          req_empty;
  logic          req_pop;
  logic          clearing;

  // Front end: classify each request by address region and load range, then queue it.
  bmm_front #(
    .ROM_BYTES (ROM_BYTES)
  ) u_front (
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .bus_address (bus_address),
    .load_offset (load_offset),
    .write_data  (write_data),
    .q_full      (req_full),
    .clearing    (clearing),
    .q_push      (req_push),
    .req         (front_req)
  );

  // Short queue that decouples the decoder from the memory back end.
  bmm_queue #(
    .WIDTH ($bits(bmm_pkg::req_t)),
    .DEPTH (REQ_DEPTH)
  ) u_req_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (req_push),
    .wdata (front_req),
    .full  (req_full),
    .pop   (req_pop),
    .rdata (back_req),
    .empty (req_empty),
    .count ()
  );

  // Back end: bank controller state, memories and the result queue.
  // State changes take effect at the edge of issue, so the next request sees them.
  bmm_back #(
    .ROM_BYTES      (ROM_BYTES),
    .CART_RAM_BYTES (CART_RAM_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (back_req),
    .req_empty (req_empty),
    .req_pop   (req_pop),
    .clearing  (clearing),
    .pop       (pop),
    .empty     (empty),
    .read_data (read_data)
  );

  // No request is taken while cartridge RAM is being cleared.
  a_full_while_clearing: assert property (@(posedge clk) clearing |-> full)
    else $error("request side open during clearing pass");

  // Nothing can be waiting when the clearing pass ends.
  a_empty_after_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> empty)
    else $error("result present before any request was taken");

  // A read taken while both queues are idle passes straight through to the result queue.
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (push && !full && (cmd == bmm_pkg::CMD_READ) && req_empty && empty) |-> ##3 !empty)
    else $error("read request produced no result in time");

endmodule
